@@ rtl/bpfa_pkg.sv @@
`timescale 1ns / 1ps

package bpfa_pkg;

    localparam int PAGES      = 4096;
    localparam int WORD_W     = 32;
    localparam int WORDS      = PAGES / WORD_W;
    localparam int WORD_AW    = $clog2(WORDS);
    localparam int BIT_AW     = $clog2(WORD_W);
    localparam int PIDX_W     = $clog2(PAGES);
    localparam int CNT_W      = 13;
    localparam int RUN_W      = CNT_W + 1;
    localparam int ADDR_W     = 48;
    localparam int SHIFT_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int STATUS_W   = 2;

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_DONE    = 2'd0,
        ST_OOM     = 2'd1,
        ST_IGNORED = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_USABLE = 2'd0,
        CFG_TOTAL  = 2'd1,
        CFG_SHIFT  = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_PASS_INIT,
        S_SCAN,
        S_FREE_SETUP,
        S_MARK_RD,
        S_MARK_WR,
        S_FINISH
    } state_t;

    typedef struct packed
    {
        logic [CNT_W-1:0]   usable_pages;
        logic [CNT_W-1:0]   total_pages;
        logic [SHIFT_W-1:0] page_shift;
    } cfg_t;

    typedef struct packed
    {
        status_t            status;
        logic [ADDR_W-1:0]  alloc_address;
        logic [CNT_W-1:0]   used_count;
        logic [CNT_W-1:0]   free_count;
    } res_t;

    // Marks the bits of one bitmap word whose page lies in [lo, hi).
    function automatic logic [WORD_W-1:0] range_mask(
        input logic [WORD_AW-1:0] word,
        input logic [RUN_W-1:0]   lo,
        input logic [RUN_W-1:0]   hi
    );
        logic [WORD_W-1:0] m;
        logic [RUN_W-1:0]  page;
        m = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            page = RUN_W'({word, BIT_AW'(i)});
            m[i] = (page >= lo) && (page < hi);
        end
        return m;
    endfunction

endpackage

@@ rtl/bitmap_page_frame_allocator_top.sv @@
`timescale 1ns / 1ps

// Next-fit page frame allocator over a 4096-page used bitmap kept as 128 words of
// 32 bits in a RAM. Each beat on the input stream is an allocate or a free request
// and yields exactly one result beat. An allocation goes through a setup state
// before each pass and then scans the 32-page words in turn, from the cursor to
// the scan limit and, if nothing fits, again from page 0 to the old cursor. A
// found run, like a freed range, is then written back word by word (read, then
// write). An ignored request goes straight to its result. The block takes one
// request at a time and is not ready while it works; a finished result sits in
// an output register until it is taken. After reset every page reads as used,
// with no clearing pass: free requests make memory available. Configuration must
// be written by the user only while the block is idle; the block does not enforce it.

module bitmap_page_frame_allocator_top
    import bpfa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [63:0]           s_axis_tdata,  // count[12:0], address[60:13]
    input  logic [0:0]            s_axis_tuser,  // operation[0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [79:0]           m_axis_tdata,  // alloc_address[47:0], used_count[60:48],
                                                 // free_count[73:61]
    output logic [STATUS_W-1:0]   m_axis_tuser,  // status[1:0]
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t               cfg_reg;
    logic               out_valid_reg;
    res_t               out_reg;
    logic               res_valid;
    logic               res_ready;
    res_t               res;
    logic               ram_we;
    logic [WORD_AW-1:0] ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [WORD_AW-1:0] ram_raddr;
    logic [WORD_W-1:0]  ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.usable_pages <= CNT_W'(4096);
            cfg_reg.total_pages  <= CNT_W'(4096);
            cfg_reg.page_shift   <= SHIFT_W'(12);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_USABLE: cfg_reg.usable_pages <= cfg_data[CNT_W-1:0];
                CFG_TOTAL:  cfg_reg.total_pages  <= cfg_data[CNT_W-1:0];
                CFG_SHIFT:  cfg_reg.page_shift   <= cfg_data[SHIFT_W-1:0];
                default:    cfg_reg              <= cfg_reg;
            endcase
        end
    end

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    bpfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .op        (op_t'(s_axis_tuser[0])),
        .count     (s_axis_tdata[CNT_W-1:0]),
        .address   (s_axis_tdata[CNT_W+ADDR_W-1:CNT_W]),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    bpfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {6'b0, out_reg.free_count, out_reg.used_count,
                            out_reg.alloc_address};

endmodule

@@ rtl/bpfa_ram.sv @@
`timescale 1ns / 1ps

module bpfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/bpfa_word_scan.sv @@
`timescale 1ns / 1ps

module bpfa_word_scan
    import bpfa_pkg::*;
(
    input  logic [WORD_W-1:0]  data,
    input  logic [WORD_AW-1:0] word,
    input  logic [RUN_W-1:0]   run_in,
    input  logic [RUN_W-1:0]   start,
    input  logic [RUN_W-1:0]   lim,
    input  logic [CNT_W-1:0]   len,
    output logic               found,
    output logic [BIT_AW-1:0]  hit_bit,
    output logic [RUN_W-1:0]   run_out
);

    logic [WORD_W-1:0] free_bits;
    logic [WORD_W-1:0] hit;
    logic [RUN_W-1:0]  run_at [WORD_W];

    // The run length ending at each bit is found in parallel from the
    // nearest used bit at or below it.
    always_comb
    begin : run_blk
        logic              have_used;
        logic [BIT_AW-1:0] last_used;
        free_bits = ~data & range_mask(word, start, lim);
        for (int i = 0; i < WORD_W; i++)
        begin
            have_used = 1'b0;
            last_used = '0;
            for (int j = 0; j <= i; j++)
            begin
                if (!free_bits[j])
                begin
                    have_used = 1'b1;
                    last_used = BIT_AW'(j);
                end
            end
            run_at[i] = have_used ? RUN_W'(BIT_AW'(i) - last_used)
                                  : run_in + RUN_W'(i + 1);
            hit[i] = run_at[i] >= RUN_W'(len);
        end
    end

    always_comb
    begin
        found   = |hit;
        hit_bit = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                hit_bit = BIT_AW'(i);
            end
        end
        run_out = run_at[WORD_W-1];
    end

endmodule

@@ rtl/bpfa_ctrl.sv @@
`timescale 1ns / 1ps

module bpfa_ctrl
    import bpfa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  op_t                op,
    input  logic [CNT_W-1:0]   count,
    input  logic [ADDR_W-1:0]  address,
    input  cfg_t               cfg,
    output logic               res_valid,
    input  logic               res_ready,
    output res_t               res,
    output logic               ram_we,
    output logic [WORD_AW-1:0] ram_waddr,
    output logic [WORD_W-1:0]  ram_wdata,
    output logic [WORD_AW-1:0] ram_raddr,
    input  logic [WORD_W-1:0]  ram_rdata
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cursor_reg, cursor_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [WORDS-1:0]   valid_reg;
    logic [WORD_AW-1:0] rd_word_reg;

    op_t                op_reg, op_next;
    status_t            status_reg, status_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [CNT_W-1:0]   old_reg, old_next;
    logic [CNT_W-1:0]   limit_reg, limit_next;
    logic               pass2_reg, pass2_next;
    logic [RUN_W-1:0]   start_reg, start_next;
    logic [RUN_W-1:0]   lim_reg, lim_next;
    logic [RUN_W-1:0]   run_reg, run_next;
    logic [RUN_W-1:0]   lo_reg, lo_next;
    logic [RUN_W-1:0]   hi_reg, hi_next;
    logic [CNT_W-1:0]   first_reg, first_next;
    logic               set_reg, set_next;
    logic [WORD_AW-1:0] word_reg, word_next;
    logic [WORD_AW-1:0] last_reg, last_next;

    logic [WORD_W-1:0]  rd_word;
    logic               found;
    logic [BIT_AW-1:0]  hit_bit;
    logic [RUN_W-1:0]   run_out;
    logic               pass_fail;
    logic [CNT_W-1:0]   used_after;
    logic [RUN_W-1:0]   used_sum;
    logic [CNT_W-1:0]   limit_v;
    logic [RUN_W-1:0]   lim_m1;
    logic [RUN_W-1:0]   end_v;
    logic [RUN_W-1:0]   end_m1;
    logic [RUN_W-1:0]   first_v;
    logic [ADDR_W-1:0]  page_v;
    logic [RUN_W-1:0]   lo_v;
    logic [RUN_W-1:0]   sum_v;
    logic [RUN_W-1:0]   hi_v;
    logic [RUN_W-1:0]   hi_m1;
    logic [WORD_W-1:0]  mask_v;

    // A word that was never written still holds its reset pattern, all used.
    assign rd_word = valid_reg[rd_word_reg] ? ram_rdata : '1;

    bpfa_word_scan u_scan (
        .data    (rd_word),
        .word    (word_reg),
        .run_in  (run_reg),
        .start   (start_reg),
        .lim     (lim_reg),
        .len     (len_reg),
        .found   (found),
        .hit_bit (hit_bit),
        .run_out (run_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cursor_reg <= '0;
            used_reg   <= '0;
            valid_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            used_reg   <= used_next;
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_word_reg <= ram_raddr;
        op_reg      <= op_next;
        status_reg  <= status_next;
        len_reg     <= len_next;
        addr_reg    <= addr_next;
        old_reg     <= old_next;
        limit_reg   <= limit_next;
        pass2_reg   <= pass2_next;
        start_reg   <= start_next;
        lim_reg     <= lim_next;
        run_reg     <= run_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        first_reg   <= first_next;
        set_reg     <= set_next;
        word_reg    <= word_next;
        last_reg    <= last_next;
    end

    always_comb
    begin
        used_sum = RUN_W'(used_reg) + RUN_W'(len_reg);
        if (op_reg == OP_ALLOC)
        begin
            used_after = used_sum[CNT_W] ? '1 : used_sum[CNT_W-1:0];
        end
        else
        begin
            used_after = (used_reg > len_reg) ? used_reg - len_reg : '0;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cursor_next = cursor_reg;
        used_next   = used_reg;
        op_next     = op_reg;
        status_next = status_reg;
        len_next    = len_reg;
        addr_next   = addr_reg;
        old_next    = old_reg;
        limit_next  = limit_reg;
        pass2_next  = pass2_reg;
        start_next  = start_reg;
        lim_next    = lim_reg;
        run_next    = run_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        first_next  = first_reg;
        set_next    = set_reg;
        word_next   = word_reg;
        last_next   = last_reg;

        in_ready  = 1'b0;
        res_valid = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = word_reg;
        ram_wdata = rd_word;
        ram_raddr = word_reg;
        pass_fail = 1'b0;

        limit_v = (cfg.usable_pages > CNT_W'(PAGES)) ? CNT_W'(PAGES) : cfg.usable_pages;
        lim_m1  = lim_reg - RUN_W'(1);
        end_v   = RUN_W'({word_reg, hit_bit}) + RUN_W'(1);
        end_m1  = end_v - RUN_W'(1);
        first_v = end_v - RUN_W'(len_reg);
        page_v  = addr_reg >> cfg.page_shift;
        lo_v    = RUN_W'(page_v[PIDX_W-1:0]);
        sum_v   = lo_v + RUN_W'(len_reg);
        hi_v    = (sum_v > RUN_W'(PAGES)) ? RUN_W'(PAGES) : sum_v;
        hi_m1   = hi_v - RUN_W'(1);
        mask_v  = range_mask(word_reg, lo_reg, hi_reg);

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next   = op;
                    len_next  = count;
                    addr_next = address;
                    if (count == '0 || (op == OP_FREE && address == '0))
                    begin
                        status_next = ST_IGNORED;
                        state_next  = S_FINISH;
                    end
                    else if (op == OP_FREE)
                    begin
                        state_next = S_FREE_SETUP;
                    end
                    else
                    begin
                        limit_next = limit_v;
                        old_next   = cursor_reg;
                        pass2_next = 1'b0;
                        start_next = RUN_W'(cursor_reg);
                        lim_next   = RUN_W'(limit_v);
                        state_next = S_PASS_INIT;
                    end
                end
            end

            S_PASS_INIT:
            begin
                ram_raddr = start_reg[PIDX_W-1:BIT_AW];
                word_next = start_reg[PIDX_W-1:BIT_AW];
                last_next = lim_m1[PIDX_W-1:BIT_AW];
                run_next  = '0;
                if (lim_reg > start_reg)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    pass_fail = 1'b1;
                end
            end

            S_SCAN:
            begin
                ram_raddr = word_reg + WORD_AW'(1);
                if (found)
                begin
                    cursor_next = end_v[CNT_W-1:0];
                    first_next  = first_v[CNT_W-1:0];
                    lo_next     = first_v;
                    hi_next     = end_v;
                    word_next   = first_v[PIDX_W-1:BIT_AW];
                    last_next   = end_m1[PIDX_W-1:BIT_AW];
                    set_next    = 1'b1;
                    state_next  = S_MARK_RD;
                end
                else if (word_reg == last_reg)
                begin
                    pass_fail = 1'b1;
                end
                else
                begin
                    word_next = word_reg + WORD_AW'(1);
                    run_next  = run_out;
                end
            end

            S_FREE_SETUP:
            begin
                if (page_v >= ADDR_W'(PAGES))
                begin
                    used_next   = used_after;
                    status_next = ST_DONE;
                    state_next  = S_FINISH;
                end
                else
                begin
                    lo_next    = lo_v;
                    hi_next    = hi_v;
                    word_next  = lo_v[PIDX_W-1:BIT_AW];
                    last_next  = hi_m1[PIDX_W-1:BIT_AW];
                    set_next   = 1'b0;
                    state_next = S_MARK_RD;
                end
            end

            S_MARK_RD:
            begin
                state_next = S_MARK_WR;
            end

            S_MARK_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = set_reg ? (rd_word | mask_v) : (rd_word & ~mask_v);
                if (word_reg == last_reg)
                begin
                    used_next   = used_after;
                    status_next = ST_DONE;
                    state_next  = S_FINISH;
                end
                else
                begin
                    word_next  = word_reg + WORD_AW'(1);
                    state_next = S_MARK_RD;
                end
            end

            S_FINISH:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // The wrapped pass starts over at page zero and ends at the old cursor or the scan limit, whichever is lower.
        if (pass_fail)
        begin
            if (!pass2_reg)
            begin
                pass2_next = 1'b1;
                start_next = '0;
                lim_next   = RUN_W'((old_reg < limit_reg) ? old_reg : limit_reg);
                state_next = S_PASS_INIT;
            end
            else
            begin
                cursor_next = lim_reg[CNT_W-1:0];
                status_next = ST_OOM;
                state_next  = S_FINISH;
            end
        end
    end

    always_comb
    begin
        res.status        = status_reg;
        res.alloc_address = (op_reg == OP_ALLOC && status_reg == ST_DONE)
                          ? (ADDR_W'(first_reg) << cfg.page_shift) : '0;
        res.used_count    = used_reg;
        res.free_count    = (cfg.total_pages > used_reg) ? cfg.total_pages - used_reg : '0;
    end

endmodule

@@ tb/page_alloc_checker.sv @@
`timescale 1ns / 1ps

module page_alloc_checker
    import bpfa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [63:0]           s_axis_tdata,
    input  logic [0:0]            s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [79:0]           m_axis_tdata,
    input  logic [STATUS_W-1:0]   m_axis_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    owed_count
);

    localparam int unsigned USED_MAX = 8191;

    bit          frame_busy [PAGES];
    int unsigned next_fit;
    int unsigned pages_in_use;
    int unsigned cfg_usable;
    int unsigned cfg_total;
    int unsigned cfg_shift;
    res_t        results_owed [$];

    // One next-fit pass over [next_fit, lim). A run never carries over between passes.
    function automatic bit claim_run(input int unsigned lim, input int unsigned len,
                                     output int unsigned first);
        int unsigned run;
        int unsigned p;
        int unsigned j;
        run = 0;
        first = 0;
        while (next_fit < lim)
        begin
            p = next_fit;
            next_fit++;
            if (!frame_busy[p])
            begin
                run++;
                if (run == len)
                begin
                    first = next_fit - len;
                    for (j = first; j < next_fit; j++)
                        frame_busy[j] = 1'b1;
                    return 1'b1;
                end
            end
            else
            begin
                run = 0;
            end
        end
        return 1'b0;
    endfunction

    function automatic res_t serve_request(input op_t op, input logic [CNT_W-1:0] cnt,
                                           input logic [ADDR_W-1:0] addr);
        res_t        r;
        int unsigned lim;
        int unsigned old;
        int unsigned first;
        bit          found;
        logic [63:0] page;
        longint unsigned k;
        r.status = ST_DONE;
        r.alloc_address = '0;
        if (op == OP_ALLOC)
        begin
            if (cnt == 0)
            begin
                r.status = ST_IGNORED;
            end
            else
            begin
                lim = (cfg_usable < PAGES) ? cfg_usable : PAGES;
                old = next_fit;
                found = claim_run(lim, 32'(cnt), first);
                if (!found)
                begin
                    next_fit = 0;
                    found = claim_run((old < lim) ? old : lim, 32'(cnt), first);
                end
                if (found)
                begin
                    r.alloc_address = ADDR_W'(64'(first) << cfg_shift);
                    pages_in_use += 32'(cnt);
                    if (pages_in_use > USED_MAX)
                        pages_in_use = USED_MAX;
                end
                else
                begin
                    r.status = ST_OOM;
                end
            end
        end
        else
        begin
            if (cnt == 0 || addr == 0)
            begin
                r.status = ST_IGNORED;
            end
            else
            begin
                page = 64'(addr) >> cfg_shift;
                for (k = 0; k < cnt; k++)
                begin
                    if (page + k < PAGES)
                        frame_busy[page + k] = 1'b0;
                end
                pages_in_use = (pages_in_use > cnt) ? pages_in_use - 32'(cnt) : 0;
            end
        end
        r.used_count = CNT_W'(pages_in_use);
        r.free_count = (cfg_total > pages_in_use) ? CNT_W'(cfg_total - pages_in_use) : '0;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s expected %0h got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            foreach (frame_busy[i])
                frame_busy[i] = 1'b1;
            next_fit     = 0;
            pages_in_use = 0;
            cfg_usable   = PAGES;
            cfg_total    = PAGES;
            cfg_shift    = 12;
            results_owed.delete();
            owed_count   = 0;
            fail_count   = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_USABLE: cfg_usable = 32'(cfg_data);
                    CFG_TOTAL:  cfg_total  = 32'(cfg_data);
                    CFG_SHIFT:  cfg_shift  = 32'(cfg_data[SHIFT_W-1:0]);
                    default:    ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                results_owed.push_back(serve_request(op_t'(s_axis_tuser[0]),
                                                     s_axis_tdata[CNT_W-1:0],
                                                     s_axis_tdata[CNT_W +: ADDR_W]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (results_owed.size() == 0)
                begin
                    $error("result beat arrived with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = results_owed.pop_front();
                    check_field("status", 64'(want.status), 64'(m_axis_tuser));
                    check_field("alloc_address", 64'(want.alloc_address),
                                64'(m_axis_tdata[47:0]));
                    check_field("used_count", 64'(want.used_count), 64'(m_axis_tdata[60:48]));
                    check_field("free_count", 64'(want.free_count), 64'(m_axis_tdata[73:61]));
                end
            end
            owed_count = results_owed.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import bpfa_pkg::*;

    localparam int     RESET_CYCLES  = 3;
    localparam int     SETTLE_CYCLES = 16;
    localparam int     TAIL_CYCLES   = 64;
    localparam int     HOLD_CYCLES   = 600;
    localparam int     PHASES        = 8;
    localparam int     PHASE_ITEMS   = 190;
    localparam longint CYCLE_LIMIT   = 4_000_000;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata  = '0;
    logic [0:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [79:0]           m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    int          fail_count;
    int          owed_count;
    int          idle_pct    = 0;
    int          stall_pct   = 0;
    bit          hold_toggle = 1'b0;
    bit          hold_seen   = 1'b0;
    int          hold_left   = 0;
    int unsigned cur_shift   = 12;
    longint      cycle_count = 0;

    bitmap_page_frame_allocator_top u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    page_alloc_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .owed_count    (owed_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // A toggle of hold_toggle starts one long stall of the result side.
    always @(negedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen     <= hold_toggle;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic logic [ADDR_W-1:0] page_addr(input int unsigned page);
        return ADDR_W'(64'(page) << cur_shift);
    endfunction

    task automatic send_beat(input op_t op, input logic [CNT_W-1:0] cnt,
                             input logic [ADDR_W-1:0] addr);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, addr, cnt};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (owed_count != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    task automatic set_config(input int unsigned usable, input int unsigned total,
                              input int unsigned shift);
        drain();
        write_reg(CFG_USABLE, CFG_DATA_W'(usable));
        write_reg(CFG_TOTAL, CFG_DATA_W'(total));
        write_reg(CFG_SHIFT, CFG_DATA_W'(shift));
        cfg_we    <= 1'b0;
        cur_shift = shift;
    endtask

    task automatic random_request();
        int unsigned      pick;
        int unsigned      page;
        logic [CNT_W-1:0] cnt;
        logic [63:0]      offset;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            if ($urandom_range(0, 99) == 0)
                cnt = CNT_W'($urandom_range(513, PAGES));
            else if ($urandom_range(0, 9) == 0)
                cnt = CNT_W'($urandom_range(17, 512));
            else
                cnt = CNT_W'($urandom_range(1, 16));
            send_beat(OP_ALLOC, cnt, ADDR_W'({$urandom(), $urandom()}));
        end
        else if (pick < 85)
        begin
            page = $urandom_range(0, PAGES - 1);
            cnt  = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom_range(33, 512))
                                               : CNT_W'($urandom_range(1, 32));
            offset = 64'($urandom()) & ((64'd1 << cur_shift) - 1);
            send_beat(OP_FREE, cnt, page_addr(page) | ADDR_W'(offset));
        end
        else
        begin
            send_beat(op_t'($urandom_range(0, 1)), CNT_W'($urandom()),
                      ($urandom_range(0, 3) == 0) ? ADDR_W'(0)
                                                  : ADDR_W'({$urandom(), $urandom()}));
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Everything reads as used after reset, so memory has to be freed first.
        send_beat(OP_ALLOC, CNT_W'(1), '0);
        send_beat(OP_ALLOC, CNT_W'(0), '0);
        send_beat(OP_FREE, CNT_W'(0), page_addr(1));
        send_beat(OP_FREE, CNT_W'(5), '0);
        send_beat(OP_FREE, CNT_W'(PAGES), 48'h1);
        send_beat(OP_ALLOC, CNT_W'(PAGES), '0);
        send_beat(OP_ALLOC, CNT_W'(1), '0);
        send_beat(OP_FREE, 13'h1FFF, 48'hFFFF_FFFF_FFFF);
        send_beat(OP_FREE, CNT_W'(100), page_addr(4050));
        send_beat(OP_ALLOC, CNT_W'(10), '0);
        // Free runs at the top and bottom of the map must not be joined across the wrap.
        send_beat(OP_FREE, CNT_W'(4), 48'h800);
        send_beat(OP_ALLOC, CNT_W'(40), '0);
        send_beat(OP_ALLOC, CNT_W'(36), '0);

        set_config(100, 0, 0);
        send_beat(OP_FREE, CNT_W'(4), 48'h1);
        send_beat(OP_ALLOC, CNT_W'(4), '0);

        set_config(8191, 8191, 31);
        send_beat(OP_FREE, CNT_W'(2), page_addr(1));
        send_beat(OP_ALLOC, CNT_W'(2), '0);
        send_beat(OP_ALLOC, CNT_W'(1), '0);

        set_config(0, PAGES, 31);
        send_beat(OP_FREE, CNT_W'(PAGES), 48'h1);
        send_beat(OP_ALLOC, CNT_W'(1), '0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 66; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 66; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            case (ph)
                0: set_config(PAGES, PAGES, 12);
                1: set_config(8191, 8191, 0);
                2: set_config(2048, 3000, 7);
                3: set_config(PAGES, PAGES, 31);
                5: set_config(300, 200, 20);
                7: set_config(PAGES, 0, 30);
                default: set_config($urandom_range(0, PAGES), $urandom_range(0, 8191),
                                    $urandom_range(0, 31));
            endcase
            if (ph == 2)
                hold_toggle = !hold_toggle;
            send_beat(OP_FREE, CNT_W'(PAGES), 48'h1);
            repeat (PHASE_ITEMS) random_request();
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/bpfa_pkg.sv
rtl/bpfa_ram.sv
rtl/bpfa_word_scan.sv
rtl/bpfa_ctrl.sv
rtl/bitmap_page_frame_allocator_top.sv
tb/page_alloc_checker.sv
tb/tb_top.sv
